[hw/rtl/f14cc_pkg.sv]
package f14cc_pkg;

    localparam int unsigned ValueW = 14;
    localparam int unsigned PartW  = 7;
    localparam int unsigned DataW  = 32;
    localparam int unsigned AddrW  = 3;

    localparam logic [ValueW-1:0] ValueMax  = 14'h3FFF;
    localparam logic [ValueW-1:0] HystReset = 14'd4;
    localparam logic [PartW-1:0]  CtrlHigh  = 7'h00;
    localparam logic [PartW-1:0]  CtrlLow   = 7'h20;

    // register index taken from paddr[2]
    localparam logic RegHysteresis = 1'b0;

    localparam logic OpSample = 1'b0;
    localparam logic OpPoll   = 1'b1;

    typedef struct packed {
        logic             has_hi;
        logic [PartW-1:0] hi;
        logic             has_lo;
        logic [PartW-1:0] lo;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[hw/rtl/f14cc_if.sv]
interface f14cc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] sample;
    logic        link_up;

    modport source (output valid, op, sample, link_up, input ready);
    modport sink (input valid, op, sample, link_up, output ready);
endinterface

interface f14cc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] controller;
    logic [6:0] cc_value;
    logic       last;

    modport source (output valid, controller, cc_value, last, input ready);
    modport sink (input valid, controller, cc_value, last, output ready);
endinterface

[hw/rtl/f14cc_front.sv]
module f14cc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    f14cc_in_if.sink                      i_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [f14cc_pkg::AddrW-1:0]   paddr,
    input  logic [f14cc_pkg::DataW-1:0]   pwdata,
    output logic [f14cc_pkg::DataW-1:0]   prdata,
    output logic                          pready,
    input  f14cc_pkg::t_q_stat            i_q_stat,
    output logic                          o_push,
    output f14cc_pkg::t_job               o_push_job
);

    logic [f14cc_pkg::ValueW-1:0] r_hyst;
    logic [f14cc_pkg::ValueW-1:0] r_sent;
    logic                         r_sent_valid;
    logic [f14cc_pkg::PartW-1:0]  r_hi;
    logic                         r_hi_valid;
    logic [f14cc_pkg::PartW-1:0]  r_lo;
    logic                         r_lo_valid;
    logic                         r_link_was_up;

    logic                         accept;
    logic                         cfg_wr;
    logic [f14cc_pkg::ValueW-1:0] v;
    logic [f14cc_pkg::ValueW-1:0] moved;
    logic                         drop;
    logic [f14cc_pkg::PartW-1:0]  hi;
    logic [f14cc_pkg::PartW-1:0]  lo;
    logic                         send_hi;
    logic                         send_lo;
    logic                         take;
    logic                         forget;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == f14cc_pkg::RegHysteresis);
    assign prdata = (paddr[2] == f14cc_pkg::RegHysteresis)
                    ? {{(f14cc_pkg::DataW - f14cc_pkg::ValueW){1'b0}}, r_hyst}
                    : '0;

    assign i_item.ready = !i_q_stat.full;
    assign accept       = i_item.valid && i_item.ready;

    assign v     = (|i_item.sample[15:14]) ? f14cc_pkg::ValueMax : i_item.sample[13:0];
    assign moved = (v >= r_sent) ? (v - r_sent) : (r_sent - v);
    assign drop  = r_sent_valid && (moved < r_hyst) && (v != '0) && (v != f14cc_pkg::ValueMax);

    assign hi      = v[13:7];
    assign lo      = v[6:0];
    assign send_hi = !r_hi_valid || (hi != r_hi);
    assign send_lo = !r_lo_valid || (lo != r_lo);

    assign take   = accept && (i_item.op == f14cc_pkg::OpSample) && !drop;
    assign forget = accept && (i_item.op == f14cc_pkg::OpPoll) && i_item.link_up
                    && !r_link_was_up;

    // suppressed while the link is down, state still moves
    assign o_push            = take && i_item.link_up && (send_hi || send_lo);
    assign o_push_job.has_hi = send_hi;
    assign o_push_job.hi     = hi;
    assign o_push_job.has_lo = send_lo;
    assign o_push_job.lo     = lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst        <= f14cc_pkg::HystReset;
            r_sent_valid  <= 1'b0;
            r_hi_valid    <= 1'b0;
            r_lo_valid    <= 1'b0;
            r_link_was_up <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_hyst <= pwdata[f14cc_pkg::ValueW-1:0];
            end
            if (accept && (i_item.op == f14cc_pkg::OpPoll)) begin
                r_link_was_up <= i_item.link_up;
            end
            if (forget) begin
                r_sent_valid <= 1'b0;
                r_hi_valid   <= 1'b0;
                r_lo_valid   <= 1'b0;
            end else if (take) begin
                r_sent_valid <= 1'b1;
                r_hi_valid   <= 1'b1;
                r_lo_valid   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sent <= v;
            if (send_hi) begin
                r_hi <= hi;
            end
            if (send_lo) begin
                r_lo <= lo;
            end
        end
    end

endmodule

[hw/rtl/f14cc_job_fifo.sv]
module f14cc_job_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  f14cc_pkg::t_job     i_push_job,
    input  logic                i_pop,
    output f14cc_pkg::t_job     o_head,
    output f14cc_pkg::t_q_stat  o_stat
);

    f14cc_pkg::t_job r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

[hw/rtl/f14cc_back.sv]
module f14cc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  f14cc_pkg::t_q_stat  i_q_stat,
    input  f14cc_pkg::t_job     i_head,
    output logic                o_pop,
    f14cc_out_if.source         o_msg
);

    f14cc_pkg::t_job             r_pend;
    logic                        r_pend_valid;
    logic                        r_out_valid;
    logic [f14cc_pkg::PartW-1:0] r_ctrl;
    logic [f14cc_pkg::PartW-1:0] r_val;
    logic                        r_last;

    logic                        load_msg;
    logic                        msg_last;

    assign o_msg.valid      = r_out_valid;
    assign o_msg.controller = r_ctrl;
    assign o_msg.cc_value   = r_val;
    assign o_msg.last       = r_last;

    // output slot free or being drained this cycle
    assign load_msg = r_pend_valid && (!r_out_valid || o_msg.ready);
    assign msg_last = !r_pend.has_hi || !r_pend.has_lo;
    assign o_pop    = !i_q_stat.empty && (!r_pend_valid || (load_msg && msg_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pend_valid <= 1'b1;
            end else if (load_msg && msg_last) begin
                r_pend_valid <= 1'b0;
            end
            if (load_msg) begin
                r_out_valid <= 1'b1;
            end else if (o_msg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pend <= i_head;
        end else if (load_msg) begin
            r_pend.has_hi <= 1'b0;
        end
        if (load_msg) begin
            r_last <= msg_last;
            if (r_pend.has_hi) begin
                r_ctrl <= f14cc_pkg::CtrlHigh;
                r_val  <= r_pend.hi;
            end else begin
                r_ctrl <= f14cc_pkg::CtrlLow;
                r_val  <= r_pend.lo;
            end
        end
    end

endmodule

[hw/rtl/fader_to_14bit_cc_filter_top.sv]
// 14-bit fader to control-change sender with hysteresis.
// i_item carries fader samples (op 0) and link status polls (op 1); a transaction
// moves on valid && ready. o_msg carries control changes: controller 0 with the
// high seven bits, then controller 32 with the low seven bits, each only when it
// differs from the last one recorded; last marks the final message of a sample.
// the hysteresis register sits at apb address 0 (14 bits, reset value 4).
// the front accepts one transaction per cycle while its two-entry job queue has
// room; the back drains one message per cycle into a registered output while
// o_msg.ready is high. a sample passes through the job queue, the pending
// register and the output register before its first message is valid. polls,
// dropped samples and samples taken with the link down produce no message.
// when o_msg.ready is low the output holds, the queue fills and then
// i_item.ready drops; nothing is lost.
// synchronous reset empties the queue and output, forgets every stored value,
// clears the link history and restores the hysteresis to 4.
module fader_to_14bit_cc_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    f14cc_in_if.sink                      i_item,
    f14cc_out_if.source                   o_msg,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [f14cc_pkg::AddrW-1:0]   paddr,
    input  logic [f14cc_pkg::DataW-1:0]   pwdata,
    output logic [f14cc_pkg::DataW-1:0]   prdata,
    output logic                          pready
);

    f14cc_pkg::t_q_stat q_stat;
    f14cc_pkg::t_job    push_job;
    f14cc_pkg::t_job    head;
    logic               push;
    logic               pop;

    f14cc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_push_job (push_job)
    );

    f14cc_job_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    f14cc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_msg    (o_msg)
    );

endmodule
